// File: sv/twf_pkg.sv
// Package for the text line folder: beat types, sequencer plan, store write port.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none
package twf_pkg;

   localparam int WORD_DEPTH = 63;
   localparam int ADDR_W     = $clog2(WORD_DEPTH);
   localparam int CNT_W      = $clog2(WORD_DEPTH + 1);
   localparam int COL_W      = 6;
   localparam int SUM_W      = 8;

   localparam logic [COL_W-1:0] COL_MAX      = 6'd63;
   localparam logic [COL_W-1:0] LINE_MAX_RST = 6'd63;
   localparam logic [7:0]       CHAR_BLANK   = 8'd32;
   localparam logic [7:0]       CHAR_NEWLINE = 8'd10;
   localparam logic             KIND_CHAR    = 1'b0;
   localparam logic             KIND_FLUSH   = 1'b1;

   typedef struct packed {
      logic       kind;
      logic [7:0] char_in;
   } req_type;

   typedef struct packed {
      logic [7:0] char_out;
      logic       last;
   } rsp_type;

   // beats of one item: optional newline, blanks, held word, optional tail byte
   typedef struct packed {
      logic             nl_pre;
      logic [COL_W-1:0] blanks;
      logic [CNT_W-1:0] wlen;
      logic             tail;
      logic [7:0]       tail_byte;
   } plan_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } wr_type;

   function automatic logic [COL_W-1:0] sat_col(input logic [SUM_W-1:0] v);
      sat_col = (v > SUM_W'(COL_MAX)) ? COL_MAX : v[COL_W-1:0];
   endfunction

endpackage
`default_nettype wire

// File: sv/text_line_folder.sv
// Top level of the greedy word wrap block: wrap decision plus beat sequencer.
// Depends on twf_pkg, twf_ctrl and twf_emit.
//
//   channel | ports                           | direction
//   --------+---------------------------------+----------
//   request | req_valid req_stall req_payload | in
//   result  | rsp_valid rsp_stall rsp_payload | out
//   csr     | csr_valid csr_ready csr_data    | in (line width)
//
// An item with no beat never raises req_stall. Newline, blank and pass-through
// beats leave one per cycle unless rsp_stall holds them; a held word byte goes
// through a store read, then the output register. req_stall is high until the
// last beat of the previous item is in the output register. Synchronous reset
// clears control; the word store is not cleared. csr_ready is always high.
`default_nettype none
module text_line_folder (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire twf_pkg::req_type  req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output twf_pkg::rsp_type       rsp_payload,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [5:0]        csr_data
);

   logic              busy, accept;
   twf_pkg::plan_type plan;
   twf_pkg::wr_type   wr;

   assign req_stall = busy;
   assign accept    = req_valid && !busy;
   assign csr_ready = 1'b1;

   twf_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_payload (req_payload),
      .csr_write   (csr_valid && csr_ready),
      .csr_data    (csr_data),
      .plan        (plan),
      .wr          (wr)
   );

   twf_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .load        (accept),
      .plan        (plan),
      .wr          (wr),
      .busy        (busy),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

// File: sv/twf_ctrl.sv
// Wrap decision: column, held run state and the limit register; builds the beat plan.
// Depends on twf_pkg.
`default_nettype none
module twf_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire twf_pkg::req_type     req_payload,
   input  wire logic                 csr_write,
   input  wire logic [5:0]           csr_data,
   output twf_pkg::plan_type         plan,
   output twf_pkg::wr_type           wr
);

   logic [twf_pkg::COL_W-1:0] line_max_ff, line_max_in;
   logic [twf_pkg::COL_W-1:0] column_ff, column_in;
   logic                      pending_ff, pending_in;
   logic [twf_pkg::COL_W-1:0] blank_ff, blank_in;
   logic [twf_pkg::CNT_W-1:0] wlen_ff, wlen_in;
   logic                      fold_ff, fold_in;
   logic                      begun_ff, begun_in;

   logic [twf_pkg::SUM_W-1:0] col_e, blk_e, wl_e, lim_e;
   logic [twf_pkg::SUM_W-1:0] sum_c1, sum_cb1, sum_all1, sum_commit, sum_cc1;
   logic [twf_pkg::COL_W-1:0] col_commit;
   logic                      commit_act, is_blank;
   logic [7:0]                ch;

   always_comb begin
      ch         = req_payload.char_in;
      is_blank   = (ch == twf_pkg::CHAR_BLANK);
      col_e      = twf_pkg::SUM_W'(column_ff);
      blk_e      = twf_pkg::SUM_W'(blank_ff);
      wl_e       = twf_pkg::SUM_W'(wlen_ff);
      lim_e      = twf_pkg::SUM_W'(line_max_ff);
      sum_c1     = col_e + 8'd1;
      sum_cb1    = col_e + blk_e + 8'd1;
      sum_all1   = col_e + blk_e + wl_e + 8'd1;
      sum_commit = col_e + blk_e + wl_e;
      col_commit = twf_pkg::sat_col(sum_commit);
      sum_cc1    = twf_pkg::SUM_W'(col_commit) + 8'd1;
      commit_act = pending_ff && !fold_ff;

      line_max_in = csr_write ? csr_data : line_max_ff;
      column_in   = column_ff;
      pending_in  = pending_ff;
      blank_in    = blank_ff;
      wlen_in     = wlen_ff;
      fold_in     = fold_ff;
      begun_in    = begun_ff;

      plan    = '0;
      wr.en   = 1'b0;
      wr.addr = wlen_ff[twf_pkg::ADDR_W-1:0];
      wr.data = ch;

      if (req_payload.kind == twf_pkg::KIND_FLUSH || ch == twf_pkg::CHAR_NEWLINE) begin
         if (commit_act) begin
            plan.blanks = blank_ff;
            plan.wlen   = wlen_ff;
         end
         if (req_payload.kind == twf_pkg::KIND_CHAR) begin
            plan.tail      = 1'b1;
            plan.tail_byte = twf_pkg::CHAR_NEWLINE;
         end
         column_in  = '0;
         pending_in = 1'b0;
         fold_in    = 1'b0;
         begun_in   = 1'b0;
         blank_in   = '0;
         wlen_in    = '0;
      end else if (!pending_ff) begin
         if (is_blank) begin
            pending_in = 1'b1;
            fold_in    = 1'b0;
            begun_in   = 1'b0;
            wlen_in    = '0;
            if (sum_c1 > lim_e) begin
               plan.tail      = 1'b1;
               plan.tail_byte = twf_pkg::CHAR_NEWLINE;
               column_in      = '0;
               fold_in        = 1'b1;
               blank_in       = '0;
            end else begin
               blank_in = 6'd1;
            end
         end else begin
            plan.tail      = 1'b1;
            plan.tail_byte = ch;
            column_in      = twf_pkg::sat_col(sum_c1);
         end
      end else if (fold_ff) begin
         if (!is_blank) begin
            plan.tail      = 1'b1;
            plan.tail_byte = ch;
            column_in      = twf_pkg::sat_col(sum_c1);
            pending_in     = 1'b0;
            fold_in        = 1'b0;
            begun_in       = 1'b0;
            blank_in       = '0;
            wlen_in        = '0;
         end
      end else if (is_blank) begin
         if (begun_ff) begin
            plan.blanks = blank_ff;
            plan.wlen   = wlen_ff;
            pending_in  = 1'b1;
            begun_in    = 1'b0;
            wlen_in     = '0;
            if (sum_cc1 > lim_e) begin
               plan.tail      = 1'b1;
               plan.tail_byte = twf_pkg::CHAR_NEWLINE;
               column_in      = '0;
               fold_in        = 1'b1;
               blank_in       = '0;
            end else begin
               column_in = col_commit;
               fold_in   = 1'b0;
               blank_in  = 6'd1;
            end
         end else if (sum_cb1 > lim_e) begin
            plan.tail      = 1'b1;
            plan.tail_byte = twf_pkg::CHAR_NEWLINE;
            column_in      = '0;
            blank_in       = '0;
            fold_in        = 1'b1;
         end else begin
            blank_in = blank_ff + 6'd1;
         end
      end else if (sum_all1 > lim_e) begin
         plan.nl_pre    = 1'b1;
         plan.wlen      = wlen_ff;
         plan.tail      = 1'b1;
         plan.tail_byte = ch;
         column_in      = twf_pkg::sat_col(wl_e + 8'd1);
         pending_in     = 1'b0;
         fold_in        = 1'b0;
         begun_in       = 1'b0;
         blank_in       = '0;
         wlen_in        = '0;
      end else if (wl_e >= twf_pkg::SUM_W'(twf_pkg::WORD_DEPTH)) begin
         plan.blanks    = blank_ff;
         plan.wlen      = wlen_ff;
         plan.tail      = 1'b1;
         plan.tail_byte = ch;
         column_in      = twf_pkg::sat_col(sum_cc1);
         pending_in     = 1'b0;
         fold_in        = 1'b0;
         begun_in       = 1'b0;
         blank_in       = '0;
         wlen_in        = '0;
      end else begin
         wr.en    = 1'b1;
         wlen_in  = wlen_ff + twf_pkg::CNT_W'(1);
         begun_in = 1'b1;
      end

      if (!accept) begin
         wr.en      = 1'b0;
         column_in  = column_ff;
         pending_in = pending_ff;
         blank_in   = blank_ff;
         wlen_in    = wlen_ff;
         fold_in    = fold_ff;
         begun_in   = begun_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_max_ff <= twf_pkg::LINE_MAX_RST;
         column_ff   <= '0;
         pending_ff  <= 1'b0;
         blank_ff    <= '0;
         wlen_ff     <= '0;
         fold_ff     <= 1'b0;
         begun_ff    <= 1'b0;
      end else begin
         line_max_ff <= line_max_in;
         column_ff   <= column_in;
         pending_ff  <= pending_in;
         blank_ff    <= blank_in;
         wlen_ff     <= wlen_in;
         fold_ff     <= fold_in;
         begun_ff    <= begun_in;
      end
   end

endmodule
`default_nettype wire

// File: sv/twf_emit.sv
// Beat sequencer: word store memory, plan counters and the result output register.
// Depends on twf_pkg.
`default_nettype none
module twf_emit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               load,
   input  wire twf_pkg::plan_type  plan,
   input  wire twf_pkg::wr_type    wr,
   output logic                    busy,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output twf_pkg::rsp_type        rsp_payload
);

   logic [7:0] mem [twf_pkg::WORD_DEPTH];
   logic [7:0] rd_data_ff;

   logic                      nl_ff, nl_in;
   logic [twf_pkg::COL_W-1:0] blanks_ff, blanks_in;
   logic [twf_pkg::CNT_W-1:0] wlen_ff, wlen_in;
   logic [twf_pkg::CNT_W-1:0] widx_ff, widx_in;
   logic                      tail_ff, tail_in;
   logic [7:0]                tbyte_ff, tbyte_in;
   logic                      primed_ff, primed_in;
   logic                      rvalid_ff, rvalid_in;
   twf_pkg::rsp_type          rdata_ff, rdata_in;

   logic free, word_phase, word_left, word_last;

   always_comb begin
      word_left  = (widx_ff != wlen_ff);
      word_last  = ((widx_ff + twf_pkg::CNT_W'(1)) == wlen_ff);
      busy       = nl_ff || (blanks_ff != '0) || word_left || tail_ff;
      word_phase = !nl_ff && (blanks_ff == '0) && word_left;
      free       = !rvalid_ff || !rsp_stall;

      nl_in     = nl_ff;
      blanks_in = blanks_ff;
      wlen_in   = wlen_ff;
      widx_in   = widx_ff;
      tail_in   = tail_ff;
      tbyte_in  = tbyte_ff;
      primed_in = 1'b0;
      rvalid_in = rvalid_ff && rsp_stall;
      rdata_in  = rdata_ff;

      if (load) begin
         nl_in     = plan.nl_pre;
         blanks_in = plan.blanks;
         wlen_in   = plan.wlen;
         widx_in   = '0;
         tail_in   = plan.tail;
         tbyte_in  = plan.tail_byte;
      end else if (word_phase) begin
         primed_in = 1'b1;
         if (primed_ff && free) begin
            primed_in         = 1'b0;
            rvalid_in         = 1'b1;
            rdata_in.char_out = rd_data_ff;
            rdata_in.last     = word_last && !tail_ff;
            widx_in           = widx_ff + twf_pkg::CNT_W'(1);
         end
      end else if (busy && free) begin
         rvalid_in = 1'b1;
         if (nl_ff) begin
            rdata_in.char_out = twf_pkg::CHAR_NEWLINE;
            rdata_in.last     = (blanks_ff == '0) && !word_left && !tail_ff;
            nl_in             = 1'b0;
         end else if (blanks_ff != '0) begin
            rdata_in.char_out = twf_pkg::CHAR_BLANK;
            rdata_in.last     = (blanks_ff == 6'd1) && !word_left && !tail_ff;
            blanks_in         = blanks_ff - 6'd1;
         end else begin
            rdata_in.char_out = tbyte_ff;
            rdata_in.last     = 1'b1;
            tail_in           = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[widx_ff[twf_pkg::ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nl_ff     <= 1'b0;
         blanks_ff <= '0;
         wlen_ff   <= '0;
         widx_ff   <= '0;
         tail_ff   <= 1'b0;
         primed_ff <= 1'b0;
         rvalid_ff <= 1'b0;
      end else begin
         nl_ff     <= nl_in;
         blanks_ff <= blanks_in;
         wlen_ff   <= wlen_in;
         widx_ff   <= widx_in;
         tail_ff   <= tail_in;
         primed_ff <= primed_in;
         rvalid_ff <= rvalid_in;
      end
      tbyte_ff <= tbyte_in;
      rdata_ff <= rdata_in;
   end

   assign rsp_valid   = rvalid_ff;
   assign rsp_payload = rdata_ff;

endmodule
`default_nettype wire
